FILE: hdl/source_connection_count_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Source connection count table: assertion macros
// Shared concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_CONNECTION_COUNT_TABLE_UNIT_ASSERT_SVH
`define SOURCE_CONNECTION_COUNT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define SCCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/scct_pkg.sv
// ----------------------------------------------------------------------------
// Source connection count table: package
// Field types, result status codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package scct_pkg;

    typedef logic [31:0] addr_t;
    typedef logic [15:0] count_t;
    typedef logic [2:0]  status_t;
    typedef logic [4:0]  index_t;

    localparam status_t STATUS_IGNORED = 3'd0;
    localparam status_t STATUS_NEW     = 3'd1;
    localparam status_t STATUS_REPEAT  = 3'd2;
    localparam status_t STATUS_OVER    = 3'd3;
    localparam status_t STATUS_FULL    = 3'd4;

    localparam count_t COUNT_MAX       = 16'hFFFF;
    localparam count_t COUNT_ONE       = 16'd1;
    localparam count_t THRESHOLD_RESET = 16'd15;

    typedef struct packed {
        addr_t addr;
        logic  first;
        logic  ignore;
    } item_t;

endpackage

`default_nettype wire

FILE: hdl/source_connection_count_table_unit.sv
// ----------------------------------------------------------------------------
// Source connection count table unit
// Counts repeats of remote IPv4 addresses within one scan of connection beats.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; a two-deep queue holds
// beats while the table is being searched, so busy rises only when it fills.
// Each beat yields exactly one result, shown for one cycle with done high;
// the receiver cannot stall. The search walks used entries through a single
// read port, one entry at a time through a read state and a compare state:
// a zero address or a beat that lands on an empty table finishes in the
// cycle after it leaves the queue, while a hit or a miss finishes after the
// compare of the matching or last used entry. No clearing pass follows reset.
`default_nettype none

module source_connection_count_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire scct_pkg::addr_t  remote_address,
    input  wire logic             first_of_scan,
    input  wire logic             cfg_wr_en,
    input  wire scct_pkg::count_t cfg_wr_data,
    output logic                  done,
    output scct_pkg::status_t     status,
    output scct_pkg::count_t      hit_count,
    output scct_pkg::index_t      entry_index
);
    import scct_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    scct_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .remote_address (remote_address),
        .first_of_scan  (first_of_scan),
        .busy           (busy),
        .q_item         (q_item),
        .q_valid        (q_valid),
        .q_pop          (q_pop)
    );

    scct_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .status      (status),
        .hit_count   (hit_count),
        .entry_index (entry_index)
    );

endmodule

`default_nettype wire

FILE: hdl/scct_front.sv
// ----------------------------------------------------------------------------
// Source connection count table: front end
// Accepts records, marks zero addresses as ignored, queues them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module scct_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire scct_pkg::addr_t remote_address,
    input  wire logic           first_of_scan,
    output logic                busy,
    output scct_pkg::item_t     q_item,
    output logic                q_valid,
    input  wire logic           q_pop
);
    import scct_pkg::*;

    item_t      fifo_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;
    item_t      in_item;

    assign busy    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = fifo_mem[rd_ptr_reg];
    assign push    = start && !busy;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        in_item.addr   = remote_address;
        in_item.first  = first_of_scan;
        in_item.ignore = (remote_address == '0);
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next      = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/scct_back.sv
// ----------------------------------------------------------------------------
// Source connection count table: back end
// Scans used entries one at a time, updates, inserts or reports full; emits one result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "source_connection_count_table_unit_assert.svh"

module scct_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scct_pkg::item_t  q_item,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire logic             cfg_wr_en,
    input  wire scct_pkg::count_t cfg_wr_data,
    output logic                  done,
    output scct_pkg::status_t     status,
    output scct_pkg::count_t      hit_count,
    output scct_pkg::index_t      entry_index
);
    import scct_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_COMP = 2'd2;

    addr_t  addr_mem [TABLE_DEPTH];
    count_t cnt_mem  [TABLE_DEPTH];

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    count_t           thr_reg;
    addr_t            cur_addr_reg;
    addr_t            cur_addr_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    addr_t            rd_addr_reg;
    count_t           rd_cnt_reg;
    logic             done_reg;
    logic             done_next;
    status_t          status_reg;
    status_t          status_next;
    count_t           hit_reg;
    count_t           hit_next;
    index_t           eidx_reg;
    index_t           eidx_next;

    logic             addr_we;
    logic             cnt_we;
    logic [IDX_W-1:0] wr_idx;
    addr_t            wr_addr;
    count_t           wr_cnt;
    logic [IDX_W-1:0] ent_idx;
    logic [IDX_W+4:0] ent_wide;
    logic [CNT_W-1:0] used_eff;
    logic             last_entry;
    count_t           cnt_inc;

    assign done        = done_reg;
    assign status      = status_reg;
    assign hit_count   = hit_reg;
    assign entry_index = eidx_reg;

    assign used_eff   = q_item.first ? '0 : used_reg;
    assign last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == used_reg);
    assign cnt_inc    = (rd_cnt_reg == COUNT_MAX) ? rd_cnt_reg : rd_cnt_reg + COUNT_ONE;
    assign ent_wide   = {5'b0, ent_idx};

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        cur_addr_next = cur_addr_reg;
        idx_next      = idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        hit_next      = hit_reg;
        eidx_next     = eidx_reg;
        q_pop         = 1'b0;
        addr_we       = 1'b0;
        cnt_we        = 1'b0;
        wr_idx        = idx_reg;
        wr_addr       = cur_addr_reg;
        wr_cnt        = COUNT_ONE;
        ent_idx       = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    cur_addr_next = q_item.addr;
                    idx_next      = '0;
                    used_next     = used_eff;
                    if (q_item.ignore)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_IGNORED;
                        hit_next    = '0;
                        eidx_next   = '0;
                    end
                    else if (used_eff == '0)
                    begin
                        ent_idx     = '0;
                        addr_we     = 1'b1;
                        cnt_we      = 1'b1;
                        wr_idx      = '0;
                        wr_addr     = q_item.addr;
                        used_next   = CNT_W'(1);
                        done_next   = 1'b1;
                        status_next = STATUS_NEW;
                        hit_next    = COUNT_ONE;
                        eidx_next   = ent_wide[4:0];
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_COMP;
            end
            S_COMP:
            begin
                if (rd_addr_reg == cur_addr_reg)
                begin
                    cnt_we      = 1'b1;
                    wr_cnt      = cnt_inc;
                    done_next   = 1'b1;
                    status_next = (cnt_inc > thr_reg) ? STATUS_OVER : STATUS_REPEAT;
                    hit_next    = cnt_inc;
                    eidx_next   = ent_wide[4:0];
                    state_next  = S_IDLE;
                end
                else if (last_entry)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (used_reg == USED_FULL)
                    begin
                        status_next = STATUS_FULL;
                        hit_next    = '0;
                        eidx_next   = '0;
                    end
                    else
                    begin
                        ent_idx     = used_reg[IDX_W-1:0];
                        addr_we     = 1'b1;
                        cnt_we      = 1'b1;
                        wr_idx      = used_reg[IDX_W-1:0];
                        used_next   = used_reg + CNT_W'(1);
                        status_next = STATUS_NEW;
                        hit_next    = COUNT_ONE;
                        eidx_next   = ent_wide[4:0];
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[wr_idx] <= wr_addr;
        end
        if (cnt_we)
        begin
            cnt_mem[wr_idx] <= wr_cnt;
        end
        if (state_reg == S_READ)
        begin
            rd_addr_reg <= addr_mem[idx_reg];
            rd_cnt_reg  <= cnt_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        eidx_reg     <= eidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            thr_reg   <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    `SCCT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= USED_FULL, "entry count past depth")
    `SCCT_ASSERT_NOW(a_scan_in_range, state_reg == S_COMP, CNT_W'(idx_reg) < used_reg,
        "scan index past used entries")
    `SCCT_ASSERT_NOW(a_empty_result,
        done_reg && (status_reg == STATUS_IGNORED || status_reg == STATUS_FULL),
        hit_reg == '0 && eidx_reg == '0, "ignored or full result carries data")
    `SCCT_ASSERT_NEXT(a_new_grows, done_next && status_next == STATUS_NEW,
        used_reg != '0 && hit_reg == COUNT_ONE, "new entry without count growth")
    `SCCT_ASSERT_NOW(a_full_only_full, done_reg && status_reg == STATUS_FULL,
        used_reg == USED_FULL, "table full reported with free entries")

endmodule

`default_nettype wire
